// ===== hdl/ucf_pkg.sv =====
// Shared types, constants and codes of the unique correspondence filter.
package ucf_pkg;

  localparam int MODEL_POINTS  = 4096;
  localparam int MOVING_POINTS = 4096;
  localparam int ADDR_W        = $clog2(MODEL_POINTS);

  typedef logic [11:0] down_idx_t;
  typedef logic [11:0] up_idx_t;
  typedef logic [31:0] dist_t;

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_FAR       = 3'd0,
    ST_TOOK      = 3'd1,
    ST_WORSE     = 3'd2,
    ST_DISPLACED = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  // One table entry per model point
  typedef struct packed {
    logic      owned;
    dist_t     best;
    down_idx_t owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Outcome of one item: result beat and table write-back
  typedef struct packed {
    status_t   status;
    down_idx_t displaced;
    logic      we;
    entry_t    wentry;
  } decide_t;

  // Clearing pass control
  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] addr;
  } sweep_t;

endpackage

// ===== hdl/ucf_if.sv =====
// Valid/ready channel interfaces for match items and result items.
interface ucf_in_if;
  import ucf_pkg::*;

  logic      valid;
  logic      ready;
  op_t       op;
  down_idx_t down_index;
  up_idx_t   nearest_up_index;
  dist_t     match_distance;

  modport source (output valid, op, down_index, nearest_up_index, match_distance,
                  input ready);
  modport sink   (input valid, op, down_index, nearest_up_index, match_distance,
                  output ready);
endinterface

interface ucf_out_if;
  import ucf_pkg::*;

  logic      valid;
  logic      ready;
  status_t   status;
  down_idx_t displaced_down_index;

  modport source (output valid, status, displaced_down_index, input ready);
  modport sink   (input valid, status, displaced_down_index, output ready);
endinterface

// ===== hdl/ucf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ucf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data while not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ucf_sweep.sv =====
// Clearing pass that zeroes the entry table after reset.
module ucf_sweep (
  input  logic            clk,
  input  logic            rst_n,
  output ucf_pkg::sweep_t sweep
);
  import ucf_pkg::*;

  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  // Advance one entry a cycle, stop after the last one
  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    if (busy_r) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == ADDR_W'(MODEL_POINTS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign sweep.busy = busy_r;
  assign sweep.addr = addr_r;

endmodule

// ===== hdl/ucf_decide.sv =====
// Offer and clear rules applied to one item and the entry read for it.
module ucf_decide (
  input  ucf_pkg::op_t       op,
  input  ucf_pkg::down_idx_t down_index,
  input  ucf_pkg::up_idx_t   up_index,
  input  ucf_pkg::dist_t     distance,
  input  ucf_pkg::dist_t     threshold,
  input  ucf_pkg::entry_t    rentry,
  output ucf_pkg::decide_t   dec
);
  import ucf_pkg::*;

  logic up_ok;
  logic down_ok;

  assign up_ok   = 32'(up_index) < MODEL_POINTS;
  assign down_ok = 32'(down_index) < MOVING_POINTS;

  // Pick the status and the entry to write back
  always_comb begin
    dec.status    = ST_FAR;
    dec.displaced = '0;
    dec.we        = 1'b0;
    dec.wentry    = rentry;
    if (op == OP_CLEAR) begin
      dec.status = ST_CLEARED;
      if (up_ok) begin
        dec.we           = 1'b1;
        dec.wentry.owned = 1'b0;
      end
    end else if (!up_ok || !down_ok) begin
      dec.status = ST_FAR;
    end else if (distance > threshold) begin
      // drop ownership, keep distance and owner
      dec.status       = ST_FAR;
      dec.we           = 1'b1;
      dec.wentry.owned = 1'b0;
    end else if (!rentry.owned) begin
      dec.status = ST_TOOK;
      dec.we     = 1'b1;
      dec.wentry = '{owned: 1'b1, best: distance, owner: down_index};
    end else if (rentry.best < distance) begin
      dec.status = ST_WORSE;
    end else begin
      // tie or closer newcomer takes over
      dec.status    = ST_DISPLACED;
      dec.displaced = rentry.owner;
      dec.we        = 1'b1;
      dec.wentry    = '{owned: 1'b1, best: distance, owner: down_index};
    end
  end

endmodule

// ===== hdl/icp_unique_correspondence_filter.sv =====
// Top level of the one-to-one correspondence filter.
//
// Channels: in_ch carries match or clear items (op, down_index,
// nearest_up_index, match_distance); out_ch returns one result beat per
// item (status, displaced_down_index). cfg_we/cfg_wdata write the distance
// threshold (unsigned Q16.16) at any clock edge.
// Each item reads its model entry from a RAM with registered read, applies
// the rules to that entry and writes it back as its result is loaded into
// the output register. A new item is accepted only after the previous one
// has left the stage register, as the entry is read and then written back.
// Reset: the threshold goes to 0 and a clearing pass zeroes all
// MODEL_POINTS entries, one per cycle; in_ch.ready stays low until it is
// done.
// Stall: one item may be accepted while a result waits in the output
// register; that item then holds, with its entry unwritten, until the
// receiver takes the waiting beat.
module icp_unique_correspondence_filter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  ucf_pkg::dist_t cfg_wdata,
  ucf_in_if.sink         in_ch,
  ucf_out_if.source      out_ch
);
  import ucf_pkg::*;

  dist_t     threshold_r;
  logic      s1_valid_r, s1_valid_nxt;
  op_t       s1_op_r;
  down_idx_t s1_down_r;
  up_idx_t   s1_up_r;
  dist_t     s1_dist_r;
  logic      out_valid_r, out_valid_nxt;
  status_t   out_status_r;
  down_idx_t out_disp_r;

  sweep_t            sweep;
  decide_t           dec;
  entry_t            rentry;
  logic              in_fire;
  logic              s1_done;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;

  ucf_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .sweep (sweep)
  );

  assign in_ch.ready = !sweep.busy && !s1_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign s1_done     = s1_valid_r && (!out_valid_r || out_ch.ready);

  // Write port: clearing pass first, else the item's write-back
  always_comb begin
    if (sweep.busy) begin
      ram_we    = 1'b1;
      ram_waddr = sweep.addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_done && dec.we;
      ram_waddr = ADDR_W'(s1_up_r);
      ram_wdata = dec.wentry;
    end
  end

  ucf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MODEL_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (ADDR_W'(in_ch.nearest_up_index)),
    .rdata (rentry)
  );

  ucf_decide u_decide (
    .op         (s1_op_r),
    .down_index (s1_down_r),
    .up_index   (s1_up_r),
    .distance   (s1_dist_r),
    .threshold  (threshold_r),
    .rentry     (rentry),
    .dec        (dec)
  );

  // Stage and output valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      threshold_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        threshold_r <= cfg_wdata;
      end
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_ch.op;
      s1_down_r <= in_ch.down_index;
      s1_up_r   <= in_ch.nearest_up_index;
      s1_dist_r <= in_ch.match_distance;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_status_r <= dec.status;
      out_disp_r   <= dec.displaced;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.status               = out_status_r;
  assign out_ch.displaced_down_index = out_disp_r;

endmodule

// ===== dv/tb.sv =====
// Testbench for the one-to-one correspondence filter: directed table, then random beats.
`timescale 1ns / 1ps

module tb;
  import ucf_pkg::*;

  localparam int RUN_LIMIT      = 400000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int DRAIN_LIMIT    = 4000;
  localparam int SEG_BEATS      = 360;
  localparam int MAX_PRINTS     = 40;

  typedef enum logic {
    ROW_BEAT      = 1'b0,
    ROW_THRESHOLD = 1'b1
  } row_kind_t;

  typedef struct packed {
    op_t       op;
    down_idx_t down;
    up_idx_t   up;
    dist_t     distance;
  } match_beat_t;

  typedef struct packed {
    status_t   status;
    down_idx_t displaced;
  } verdict_t;

  // Directed row: a beat, or a threshold write carried in distance
  typedef struct packed {
    row_kind_t kind;
    op_t       op;
    down_idx_t down;
    up_idx_t   up;
    dist_t     distance;
    logic      typed;
    status_t   status;
    down_idx_t displaced;
  } stim_row_t;

  localparam int NUM_ROWS = 24;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_BEAT, OP_OFFER, 12'd5, 12'd0, 32'd0, 1'b1, ST_TOOK, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd6, 12'd0, 32'd1, 1'b1, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd7, 12'd0, 32'd0, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'hFFF, 12'hFFF, 32'd0, 1'b1, ST_TOOK, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd0, 12'hFFF, 32'd0, 1'b1, ST_DISPLACED, 12'hFFF},
    '{ROW_BEAT, OP_CLEAR, 12'd0, 12'hFFF, 32'd0, 1'b1, ST_CLEARED, 12'd0},
    '{ROW_BEAT, OP_CLEAR, 12'd0, 12'hFFF, 32'd0, 1'b1, ST_CLEARED, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd1, 12'hFFF, 32'd0, 1'b0, ST_FAR, 12'd0},
    '{ROW_THRESHOLD, OP_OFFER, 12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd10, 12'd1, 32'hFFFF_FFFF, 1'b1, ST_TOOK, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd11, 12'd1, 32'hFFFF_FFFF, 1'b1, ST_DISPLACED, 12'd10},
    '{ROW_BEAT, OP_OFFER, 12'd12, 12'd1, 32'h0001_0000, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd13, 12'd1, 32'h0002_0000, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd12, 12'd1, 32'h0001_0000, 1'b0, ST_FAR, 12'd0},
    '{ROW_THRESHOLD, OP_OFFER, 12'd0, 12'd0, 32'h0001_8000, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd14, 12'd1, 32'h0001_8001, 1'b1, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd15, 12'd1, 32'h0001_8000, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'hAAA, 12'h555, 32'h0001_5555, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'h555, 12'hAAA, 32'h0000_AAAA, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_CLEAR, 12'hFFF, 12'd1, 32'hFFFF_FFFF, 1'b1, ST_CLEARED, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd16, 12'd1, 32'h0001_8000, 1'b0, ST_FAR, 12'd0},
    '{ROW_THRESHOLD, OP_OFFER, 12'd0, 12'd0, 32'd0, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd17, 12'd2, 32'd0, 1'b0, ST_FAR, 12'd0},
    '{ROW_BEAT, OP_OFFER, 12'd18, 12'd2, 32'd1, 1'b1, ST_FAR, 12'd0}
  };

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_we = 1'b0;
  dist_t          cfg_wdata = '0;

  ucf_in_if  in_ch ();
  ucf_out_if out_ch ();

  icp_unique_correspondence_filter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Local copy of the ownership table and threshold
  logic      entry_taken [MODEL_POINTS];
  dist_t     entry_dist  [MODEL_POINTS];
  down_idx_t entry_owner [MODEL_POINTS];
  dist_t     cur_threshold = '0;

  verdict_t  pending_verdicts [$];
  verdict_t  got_verdict;
  verdict_t  want_verdict;

  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  bit        rx_hold_req = 1'b0;
  int        mismatch_count = 0;
  int        beats_sent = 0;
  int        results_seen = 0;
  int        status_seen [5] = '{0, 0, 0, 0, 0};
  int        cycle_count = 0;

  always #5 clk = ~clk;

  // Count one mismatch and print the first few
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] MISMATCH %s", $time, what);
    end
  endtask

  // Apply the ownership rules to one beat and return its verdict
  function automatic verdict_t resolve_match(input match_beat_t b);
    verdict_t v;
    v.status    = ST_FAR;
    v.displaced = '0;
    if (b.op == OP_CLEAR) begin
      if (int'(b.up) < MODEL_POINTS) entry_taken[b.up] = 1'b0;
      v.status = ST_CLEARED;
    end else if (int'(b.up) >= MODEL_POINTS || int'(b.down) >= MOVING_POINTS) begin
      v.status = ST_FAR;
    end else if (b.distance > cur_threshold) begin
      entry_taken[b.up] = 1'b0;
      v.status = ST_FAR;
    end else if (!entry_taken[b.up]) begin
      entry_taken[b.up] = 1'b1;
      entry_dist[b.up]  = b.distance;
      entry_owner[b.up] = b.down;
      v.status = ST_TOOK;
    end else if (entry_dist[b.up] < b.distance) begin
      v.status = ST_WORSE;
    end else begin
      v.displaced       = entry_owner[b.up];
      entry_dist[b.up]  = b.distance;
      entry_owner[b.up] = b.down;
      v.status = ST_DISPLACED;
    end
    return v;
  endfunction

  // Random beat aimed at a small hot set of entries so that owners collide
  function automatic match_beat_t random_beat();
    match_beat_t b;
    int          pick;
    b.op   = ($urandom_range(99) < 12) ? OP_CLEAR : OP_OFFER;
    b.down = down_idx_t'($urandom_range(4095));
    pick   = $urandom_range(99);
    if (pick < 70) b.up = up_idx_t'($urandom_range(31));
    else if (pick < 90) b.up = up_idx_t'($urandom_range(4095));
    else b.up = up_idx_t'(4095 - $urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 25 && entry_taken[b.up]) begin
      b.distance = entry_dist[b.up] + dist_t'($urandom_range(1));
    end else if (pick < 25) begin
      b.distance = cur_threshold;
    end else if (pick < 65) begin
      b.distance = $urandom_range(cur_threshold, 0);
    end else if (pick < 85 && cur_threshold != '1) begin
      b.distance = $urandom_range(32'hFFFF_FFFF, cur_threshold + 1);
    end else begin
      b.distance = $urandom;
    end
    return b;
  endfunction

  // Offer one beat after a random gap; predict once it is accepted
  task automatic offer_beat(input match_beat_t b, input bit typed, input verdict_t typed_v);
    verdict_t v;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.op               <= b.op;
    in_ch.down_index       <= b.down;
    in_ch.nearest_up_index <= b.up;
    in_ch.match_distance   <= b.distance;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    v = resolve_match(b);
    if (typed) v = typed_v;
    pending_verdicts = {pending_verdicts, v};
    beats_sent++;
  endtask

  // Write the threshold once every result is back
  task automatic set_threshold(input dist_t value);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    cur_threshold = value;
  endtask

  task automatic run_segment(input int tx_pct, input int rx_pct, input dist_t thr);
    match_beat_t b;
    set_threshold(thr);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    rx_hold_req = 1'b1;
    for (int i = 0; i < SEG_BEATS; i++) begin
      b = random_beat();
      offer_beat(b, 1'b0, '0);
    end
  endtask

  // Receiver: random backpressure, plus a long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_verdict.status    = out_ch.status;
      got_verdict.displaced = out_ch.displaced_down_index;
      results_seen++;
      if (int'(got_verdict.status) < 5) status_seen[int'(got_verdict.status)]++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("result status %0d with nothing expected",
                                got_verdict.status));
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (got_verdict.status != want_verdict.status) begin
          flag_mismatch($sformatf("status got %0d want %0d",
                                  got_verdict.status, want_verdict.status));
        end
        if (got_verdict.displaced != want_verdict.displaced) begin
          flag_mismatch($sformatf("displaced index got %0d want %0d",
                                  got_verdict.displaced, want_verdict.displaced));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          waited;
    match_beat_t b;
    verdict_t    tv;
    in_ch.valid            = 1'b0;
    in_ch.op               = OP_OFFER;
    in_ch.down_index       = '0;
    in_ch.nearest_up_index = '0;
    in_ch.match_distance   = '0;
    for (int i = 0; i < MODEL_POINTS; i++) begin
      entry_taken[i] = 1'b0;
      entry_dist[i]  = '0;
      entry_owner[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: reset threshold, extremes, ties, clears
    tx_idle_pct = 27;
    rx_idle_pct = 83;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_THRESHOLD) begin
        set_threshold(directed_rows[r].distance);
      end else begin
        b.op           = directed_rows[r].op;
        b.down         = directed_rows[r].down;
        b.up           = directed_rows[r].up;
        b.distance     = directed_rows[r].distance;
        tv.status      = directed_rows[r].status;
        tv.displaced   = directed_rows[r].displaced;
        offer_beat(b, directed_rows[r].typed, tv);
      end
    end

    // Random segments: shift the idling, sweep the threshold
    run_segment(27, 83, 32'h0080_0000);
    run_segment(83, 27, 32'hFFFF_FFFF);
    run_segment(0, 0, $urandom | 32'h0000_0100);
    run_segment(0, 0, 32'h0000_0000);

    // Drain, then allow for the pipeline
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_verdicts.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d beats, %0d results over four threshold settings",
             beats_sent, results_seen);
    $display("Outcomes: far %0d, took %0d, worse %0d, displaced %0d, cleared %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
